[rtl/ncov_pkg.sv]
// ncov_pkg: shared sizes, command and status codes, divider control types
// and the lower-triangle address function for the covariance accumulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ncov_pkg;

  localparam int MAX_VARS   = 8;
  localparam int FRAC_BITS  = 16;
  localparam int VAR_W      = $clog2(MAX_VARS);
  localparam int NV_W       = VAR_W + 1;
  localparam int TRI_SIZE   = MAX_VARS * (MAX_VARS + 1) / 2;
  localparam int TRI_W      = $clog2(TRI_SIZE);
  localparam int SAMPLE_W   = 32;
  localparam int VSUM_W     = 48;
  localparam int PSUM_W     = 64;
  localparam int DVD_W      = PSUM_W + FRAC_BITS;
  localparam int STEP_W     = $clog2(DVD_W + 1);
  localparam int RUNS_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_SCALE  = 2'd1;
  localparam cmd_t CMD_SAMPLE = 2'd2;
  localparam cmd_t CMD_READ   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ZSCALE = 2'd1;
  localparam status_t ST_RANGE  = 2'd2;
  localparam status_t ST_SAT    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_VARS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUNS = 1'b1;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // packed lower triangle: row r, column c with c <= r
  function automatic logic [TRI_W-1:0] tri_addr(input logic [VAR_W-1:0] r,
                                                input logic [VAR_W-1:0] c);
    logic [TRI_W-1:0] prod;
    prod = TRI_W'(r) * (TRI_W'(r) + TRI_W'(1));
    return (prod >> 1) + TRI_W'(c);
  endfunction

endpackage

`default_nettype wire

[rtl/ncov_if.sv]
// ncov_in_if / ncov_out_if: valid-ready channels for command beats and
// result beats. Depends on ncov_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ncov_in_if import ncov_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic [2:0]            var_index;
  logic [2:0]            other_index;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, cmd, var_index, other_index, sample, input ready);
  modport sink   (input valid, cmd, var_index, other_index, sample, output ready);
endinterface

interface ncov_out_if import ncov_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    result;
  logic [1:0]            status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

`default_nettype wire

[rtl/ncov_div.sv]
// ncov_div: unsigned restoring divider, one quotient bit per cycle.
// Dividend is left aligned; steps sets how many top bits are consumed.
// Depends on ncov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncov_div import ncov_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_ctl_t          ctl,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [PSUM_W-1:0] divisor,
  output      div_sts_t          sts,
  output      logic [DVD_W-1:0]  quotient
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [PSUM_W-1:0] rem_r;
  logic [PSUM_W-1:0] dsr_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quot_r;

  logic [PSUM_W:0]   trial;
  logic              ge;
  logic [PSUM_W-1:0] rem_nxt;

  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = trial >= {1'b0, dsr_r};
  // a failed trial is below the divisor, so it fits the remainder width
  assign rem_nxt = ge ? PSUM_W'(trial - {1'b0, dsr_r}) : trial[PSUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r  <= '0;
      quot_r <= '0;
      dvd_r  <= dividend;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[DVD_W-2:0], ge};
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire

[rtl/normalized_covariance_accumulator_top.sv]
// normalized_covariance_accumulator_top: sequencer, sum stores, shared
// multiplier and product-sum memory. Depends on ncov_pkg, ncov_if, ncov_div.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        cmd, var_index, other_index, sample
//   out_ch   out  valid/ready        result, status
//   cfg_*    in   cfg_we only        cfg_index, cfg_data
//
// clear and load scale go straight to the result state; a sample at position i
// makes i+1 terms, one shared 32x32 multiply and one memory read-modify-write
// per term. a read of two variables in range with nonzero scales runs the
// bit-serial divider four times, for quotients of 48, 48, 64 and 80 bits.
// ready is high only while the sequencer is idle; one finished result may wait
// in the output register while the next beat is taken.
// reset is synchronous and resets sums, valid bits, position, state and config.
`timescale 1ns / 1ps
`default_nettype none

module normalized_covariance_accumulator_top import ncov_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ncov_in_if.sink                    in_ch,
  ncov_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_DEN  = 4'd3;
  localparam logic [3:0] S_DCHK = 4'd4;
  localparam logic [3:0] S_DMR  = 4'd5;
  localparam logic [3:0] S_DMC  = 4'd6;
  localparam logic [3:0] S_DSB  = 4'd7;
  localparam logic [3:0] S_MM   = 4'd8;
  localparam logic [3:0] S_COV  = 4'd9;
  localparam logic [3:0] S_CQ   = 4'd10;
  localparam logic [3:0] S_DQ   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clamp_t;

  function automatic clamp_t clamp_q(input logic [DVD_W-1:0] q, input logic neg);
    clamp_t o;
    o.sat = 1'b0;
    if (neg) begin
      if (q > DVD_W'(32'h8000_0000)) begin
        o.sat = 1'b1;
        o.val = 32'h8000_0000;
      end else begin
        o.val = 32'h0 - q[31:0];
      end
    end else begin
      if (q > DVD_W'(32'h7fff_ffff)) begin
        o.sat = 1'b1;
        o.val = 32'h7fff_ffff;
      end else begin
        o.val = q[31:0];
      end
    end
    return o;
  endfunction

  // configuration
  logic [3:0]        vars_r;
  logic [RUNS_W-1:0] runs_r;
  logic [NV_W-1:0]   n_eff;
  logic [PSUM_W-1:0] runs64;

  // stores
  logic [31:0]       scale_r [MAX_VARS];
  logic [31:0]       rv_r    [MAX_VARS];
  logic [VSUM_W-1:0] vs_r    [MAX_VARS];
  logic [PSUM_W-1:0] psum_mem [TRI_SIZE];
  logic [TRI_SIZE-1:0] pv_r;

  // sequencer
  logic [3:0]          state_r;
  logic [VAR_W-1:0]    pos_r;
  logic [VAR_W-1:0]    i_r;
  logic [VAR_W-1:0]    j_r;
  logic [VAR_W-1:0]    r_r;
  logic [VAR_W-1:0]    c_r;
  logic [TRI_W-1:0]    addr_r;
  logic signed [31:0]  smp_r;
  logic signed [63:0]  prod_r;
  logic [PSUM_W-1:0]   mem_q_r;
  logic                pv_q_r;
  logic [PSUM_W-1:0]   ps_r;
  logic signed [63:0]  den_r;
  logic signed [31:0]  mr_r;
  logic signed [31:0]  mc_r;
  logic signed [63:0]  sbar_r;
  logic signed [63:0]  cov_r;
  logic                neg_r;
  logic                sat_r;
  logic [1:0]          status_r;
  logic [31:0]         result_r;

  logic                out_valid_r;
  logic [31:0]         out_result_r;
  logic [1:0]          out_status_r;

  logic                in_acc;
  logic                out_load;
  logic [VAR_W-1:0]    i_start;
  logic [NV_W-1:0]     i_inc;
  logic [VAR_W-1:0]    vi;
  logic [VAR_W-1:0]    oi;

  logic signed [31:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [63:0]  mul_p;
  logic [TRI_W-1:0]    mem_raddr;
  logic [PSUM_W-1:0]   acc_sum;

  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [DVD_W-1:0]    div_dvd;
  logic [PSUM_W-1:0]   div_dsr;
  logic [DVD_W-1:0]    div_q;

  logic [VSUM_W-1:0]   vs_sel;
  logic [VSUM_W-1:0]   vs_mag;
  logic [PSUM_W-1:0]   ps_mag;
  logic [PSUM_W-1:0]   cov_mag;
  logic [PSUM_W-1:0]   den_mag;
  logic [PSUM_W:0]     diff;
  logic                cov_ovf;
  clamp_t              cl;
  logic [PSUM_W-1:0]   sb_val;

  assign vi = in_ch.var_index;
  assign oi = in_ch.other_index;

  always_comb begin
    if (vars_r == 4'd0) begin
      n_eff = NV_W'(1);
    end else if (NV_W'(vars_r) > NV_W'(MAX_VARS)) begin
      n_eff = NV_W'(MAX_VARS);
    end else begin
      n_eff = NV_W'(vars_r);
    end
  end

  assign runs64   = (runs_r == '0) ? PSUM_W'(1) : PSUM_W'(runs_r);
  assign in_acc   = in_ch.valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign i_start  = ({1'b0, pos_r} >= n_eff) ? '0 : pos_r;
  assign i_inc    = NV_W'(i_r) + NV_W'(1);

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_MUL: begin
        mul_a = smp_r;
        mul_b = $signed(rv_r[j_r]);
      end
      S_DEN: begin
        mul_a = $signed(scale_r[r_r]);
        mul_b = $signed(scale_r[c_r]);
      end
      default: begin
        mul_a = mr_r;
        mul_b = mc_r;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (state_r)
      S_MUL:   mem_raddr = tri_addr(i_r, j_r);
      S_DEN:   mem_raddr = tri_addr(r_r, c_r);
      default: mem_raddr = addr_r;
    endcase
  end

  assign acc_sum = (pv_q_r ? mem_q_r : '0) + PSUM_W'(prod_r);

  // product-sum memory, registered read
  always_ff @(posedge clk) begin
    if (state_r == S_ACC) begin
      psum_mem[addr_r] <= acc_sum;
    end
    mem_q_r <= psum_mem[mem_raddr];
  end

  // divider operands
  assign vs_sel  = (state_r == S_DCHK) ? vs_r[r_r] : vs_r[c_r];
  assign vs_mag  = vs_sel[VSUM_W-1] ? (VSUM_W'(0) - vs_sel) : vs_sel;
  assign ps_mag  = ps_r[PSUM_W-1] ? (PSUM_W'(0) - ps_r) : ps_r;
  assign cov_mag = cov_r[63] ? (PSUM_W'(0) - PSUM_W'(cov_r)) : PSUM_W'(cov_r);
  assign den_mag = den_r[63] ? (PSUM_W'(0) - PSUM_W'(den_r)) : PSUM_W'(den_r);

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = STEP_W'(VSUM_W);
    div_dvd       = {vs_mag, {(DVD_W-VSUM_W){1'b0}}};
    div_dsr       = runs64;
    unique case (state_r)
      S_DCHK: div_ctl.start = (prod_r != '0);
      S_DMR:  div_ctl.start = div_sts.done;
      S_DMC: begin
        div_ctl.start = div_sts.done;
        div_ctl.steps = STEP_W'(PSUM_W);
        div_dvd       = {ps_mag, {FRAC_BITS{1'b0}}};
      end
      S_CQ: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(DVD_W);
        div_dvd       = {cov_mag, {FRAC_BITS{1'b0}}};
        div_dsr       = den_mag;
      end
      default: begin
      end
    endcase
  end

  ncov_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // saturating sign restore of the divider result
  always_comb begin
    unique case (state_r)
      S_DMR:   cl = clamp_q(div_q, vs_r[r_r][VSUM_W-1]);
      S_DMC:   cl = clamp_q(div_q, vs_r[c_r][VSUM_W-1]);
      default: cl = clamp_q(div_q, neg_r);
    endcase
  end

  assign sb_val  = ps_r[PSUM_W-1] ? (PSUM_W'(0) - div_q[PSUM_W-1:0]) : div_q[PSUM_W-1:0];
  assign diff    = {sbar_r[63], sbar_r} - {prod_r[63], prod_r};
  assign cov_ovf = diff[PSUM_W] != diff[PSUM_W-1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vars_r <= 4'd8;
      runs_r <= RUNS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VARS: vars_r <= cfg_data[3:0];
        CFG_RUNS: runs_r <= cfg_data;
      endcase
    end
  end

  // scale and run value stores, undefined until written
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == CMD_SCALE && {1'b0, vi} < n_eff) begin
      scale_r[vi] <= in_ch.sample;
    end
    if (in_acc && in_ch.cmd == CMD_SAMPLE) begin
      rv_r[i_start] <= in_ch.sample;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_VARS; k++) begin
        vs_r[k] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.cmd)
              CMD_CLEAR: begin
                pv_r  <= '0;
                pos_r <= '0;
                for (int k = 0; k < MAX_VARS; k++) begin
                  vs_r[k] <= '0;
                end
                state_r <= S_DONE;
              end
              CMD_SCALE: state_r <= S_DONE;
              CMD_SAMPLE: begin
                vs_r[i_start] <= vs_r[i_start]
                                 + {{(VSUM_W-SAMPLE_W){in_ch.sample[SAMPLE_W-1]}},
                                    in_ch.sample};
                state_r <= S_MUL;
              end
              CMD_READ: begin
                if ({1'b0, vi} >= n_eff || {1'b0, oi} >= n_eff) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_DEN;
                end
              end
            endcase
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          pv_r[addr_r] <= 1'b1;
          if (j_r == i_r) begin
            pos_r   <= (i_inc >= n_eff) ? '0 : i_inc[VAR_W-1:0];
            state_r <= S_DONE;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_DEN: state_r <= S_DCHK;
        S_DCHK: state_r <= (prod_r == '0) ? S_DONE : S_DMR;
        S_DMR: if (div_sts.done) state_r <= S_DMC;
        S_DMC: if (div_sts.done) state_r <= S_DSB;
        S_DSB: if (div_sts.done) state_r <= S_MM;
        S_MM:  state_r <= S_COV;
        S_COV: state_r <= S_CQ;
        S_CQ:  state_r <= S_DQ;
        S_DQ:  if (div_sts.done) state_r <= S_DONE;
        S_DONE: if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          smp_r    <= in_ch.sample;
          i_r      <= i_start;
          j_r      <= '0;
          r_r      <= (vi > oi) ? vi : oi;
          c_r      <= (vi > oi) ? oi : vi;
          sat_r    <= 1'b0;
          result_r <= '0;
          if ((in_ch.cmd == CMD_SCALE && {1'b0, vi} >= n_eff) ||
              (in_ch.cmd == CMD_READ &&
               ({1'b0, vi} >= n_eff || {1'b0, oi} >= n_eff))) begin
            status_r <= ST_RANGE;
          end else begin
            status_r <= ST_OK;
          end
        end
      end
      S_MUL: begin
        prod_r <= mul_p;
        addr_r <= mem_raddr;
        pv_q_r <= pv_r[mem_raddr];
      end
      S_ACC: j_r <= j_r + VAR_W'(1);
      S_DEN: begin
        prod_r <= mul_p;
        addr_r <= mem_raddr;
        pv_q_r <= pv_r[mem_raddr];
      end
      S_DCHK: begin
        den_r <= prod_r;
        ps_r  <= pv_q_r ? mem_q_r : '0;
        if (prod_r == '0) begin
          status_r <= ST_ZSCALE;
        end
      end
      S_DMR: begin
        if (div_sts.done) begin
          mr_r  <= cl.val;
          sat_r <= sat_r | cl.sat;
        end
      end
      S_DMC: begin
        if (div_sts.done) begin
          mc_r  <= cl.val;
          sat_r <= sat_r | cl.sat;
        end
      end
      S_DSB: if (div_sts.done) sbar_r <= sb_val;
      S_MM: prod_r <= mul_p;
      S_COV: begin
        if (cov_ovf) begin
          cov_r <= diff[PSUM_W] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
          sat_r <= 1'b1;
        end else begin
          cov_r <= diff[PSUM_W-1:0];
        end
        neg_r <= (diff[PSUM_W] != den_r[63]);
      end
      S_DQ: begin
        if (div_sts.done) begin
          result_r <= cl.val;
          status_r <= (sat_r || cl.sat) ? ST_SAT : ST_OK;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_result_r <= result_r;
      out_status_r <= status_r;
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;
  assign out_ch.status = out_status_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted beat left sequencer idle");

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_flag_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_ZSCALE || out_status_r == ST_RANGE))
      |-> out_result_r == '0)
    else $error("flagged read carries a nonzero result");

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_ACC) |-> j_r <= i_r)
    else $error("product term beyond current variable");

endmodule

`default_nettype wire

[tb/tb.sv]
// tb: self-checking bench for normalized_covariance_accumulator_top, with a
// bit-exact covariance predictor, random idling on both channels and a watchdog.
// Depends on ncov_pkg, ncov_if and the rtl top.
`timescale 1ns / 1ps

module tb;
  import ncov_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [31:0] result;
    status_t     code;
  } cov_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ncov_in_if in_ch ();
  ncov_out_if out_ch ();

  normalized_covariance_accumulator_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] scales [MAX_VARS];
  logic [31:0] last_vec [MAX_VARS];
  logic [47:0] mean_acc [MAX_VARS];
  logic [63:0] cross_acc [TRI_SIZE];
  int unsigned vec_pos;
  logic [3:0] vars_reg;
  logic [15:0] runs_reg;

  cov_beat_t expected_q[$];
  int mismatches = 0;
  bit steady = 0;       // no idling on either side
  int hold_req = 0;
  int hold_left = 0;
  int idle_count = 0;

  function automatic int unsigned active_vars();
    if (vars_reg == 0) return 1;
    if (vars_reg > MAX_VARS) return MAX_VARS;
    return vars_reg;
  endfunction

  function automatic int unsigned tri_slot(int unsigned r, int unsigned c);
    return r * (r + 1) / 2 + c;
  endfunction

  function automatic longint clamp_word(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void covariance_of(int unsigned a, int unsigned b,
                                        output logic [31:0] res, output status_t code);
    int unsigned n, r, c;
    longint den, runs, mr, mc, sbar, mm, cov;
    logic [63:0] num_mag, den_mag;
    logic [79:0] quot;
    bit sat, neg;
    n = active_vars();
    res = '0;
    sat = 0;
    if (a >= n || b >= n) begin
      code = ST_RANGE;
      return;
    end
    r = a > b ? a : b;
    c = a > b ? b : a;
    den = longint'($signed(scales[r])) * longint'($signed(scales[c]));
    if (den == 0) begin
      code = ST_ZSCALE;
      return;
    end
    runs = runs_reg == 0 ? 1 : longint'(runs_reg);
    mr = clamp_word(longint'($signed(mean_acc[r])) / runs, sat);
    mc = clamp_word(longint'($signed(mean_acc[c])) / runs, sat);
    sbar = $signed(cross_acc[tri_slot(r, c)]) / runs;
    mm = mr * mc;
    if (mm > 0 && sbar < (64'sh8000000000000000 + mm)) begin
      cov = 64'sh8000000000000000;
      sat = 1;
    end else if (mm < 0 && sbar > (64'sh7fffffffffffffff + mm)) begin
      cov = 64'sh7fffffffffffffff;
      sat = 1;
    end else begin
      cov = sbar - mm;
    end
    neg = (cov < 0) != (den < 0);
    num_mag = cov < 0 ? 64'd0 - 64'(cov) : 64'(cov);
    den_mag = den < 0 ? 64'd0 - 64'(den) : 64'(den);
    quot = ({16'd0, num_mag} << FRAC_BITS) / {16'd0, den_mag};
    if (neg) begin
      if (quot > 80'd2147483648) begin
        res = 32'h80000000;
        sat = 1;
      end else begin
        res = 32'd0 - quot[31:0];
      end
    end else begin
      if (quot > 80'd2147483647) begin
        res = 32'h7fffffff;
        sat = 1;
      end else begin
        res = quot[31:0];
      end
    end
    code = sat ? ST_SAT : ST_OK;
  endfunction

  function automatic cov_beat_t predict_beat(cmd_t cmd, logic [2:0] vi, logic [2:0] oi,
                                             logic [31:0] raw);
    cov_beat_t e;
    int unsigned n, i;
    longint s;
    e.result = '0;
    e.code = ST_OK;
    n = active_vars();
    case (cmd)
      CMD_CLEAR: begin
        foreach (mean_acc[k]) mean_acc[k] = '0;
        foreach (cross_acc[k]) cross_acc[k] = '0;
        vec_pos = 0;
      end
      CMD_SCALE: begin
        if (vi < n) scales[vi] = raw;
        else e.code = ST_RANGE;
      end
      CMD_SAMPLE: begin
        if (vec_pos >= n) vec_pos = 0;
        i = vec_pos;
        s = longint'($signed(raw));
        last_vec[i] = raw;
        mean_acc[i] = mean_acc[i] + 48'(s);
        for (int unsigned j = 0; j <= i; j++)
          cross_acc[tri_slot(i, j)] += 64'(s * longint'($signed(last_vec[j])));
        vec_pos = (i + 1 >= n) ? 0 : i + 1;
      end
      default: covariance_of(vi, oi, e.result, e.code);
    endcase
    return e;
  endfunction

  // ---------------- driving ----------------
  task automatic send_beat(cmd_t cmd, logic [2:0] vi = 3'd0, logic [2:0] oi = 3'd0,
                           logic [31:0] raw = 32'd0);
    int gap;
    gap = (!steady && $urandom_range(99) < 27) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.var_index <= vi;
    in_ch.other_index <= oi;
    in_ch.sample <= raw;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_beat(cmd, vi, oi, raw));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_VARS) vars_reg = val[3:0];
    else runs_reg = val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] nv, logic [15:0] runs);
    drain();
    write_reg(CFG_VARS, nv);
    write_reg(CFG_RUNS, runs);
  endtask

  function automatic logic [31:0] rand_sample();
    if ($urandom_range(99) < 70) return 32'($urandom_range(2097152)) - 32'd1048576;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_scale();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return 32'd0;
    if (pick < 20) return $urandom;
    if (pick < 30) return 32'd0 - 32'($urandom_range(1, 32'h40000));
    return 32'($urandom_range(1, 32'h40000));
  endfunction

  // ---------------- receiving ----------------
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left <= hold_req;
      hold_req <= 0;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    cov_beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: result %h code %0d", out_ch.result,
                   out_ch.status);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.result !== e.result || out_ch.status !== e.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected result %h code %0d, got result %h code %0d",
                     e.result, e.code, out_ch.result, out_ch.status);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_basic();
    logic [31:0] vec [8] = '{32'h7fffffff, 32'h80000000, 32'd0, 32'hffffffff,
                             32'd1, 32'h00010000, 32'hffff0000, 32'h00008000};
    send_beat(CMD_CLEAR);
    for (int v = 0; v < 7; v++) send_beat(CMD_SCALE, 3'(v), 3'd0, 32'h00010000);
    send_beat(CMD_SCALE, 3'd7, 3'd0, 32'd0);   // zero scale
    foreach (vec[k]) send_beat(CMD_SAMPLE, 3'd0, 3'd0, vec[k]);
    send_beat(CMD_READ, 3'd0, 3'd0);
    send_beat(CMD_READ, 3'd3, 3'd1);
    send_beat(CMD_READ, 3'd1, 3'd3);
    send_beat(CMD_READ, 3'd5, 3'd6);
    send_beat(CMD_READ, 3'd2, 3'd7);
    send_beat(CMD_READ, 3'd7, 3'd7);
  endtask

  task automatic test_register_edges();
    set_regs(16'd3, 16'd65535);
    send_beat(CMD_SCALE, 3'd5, 3'd0, 32'h1234);    // beyond vars in use
    send_beat(CMD_READ, 3'd4, 3'd1);
    send_beat(CMD_READ, 3'd0, 3'd3);
    send_beat(CMD_SAMPLE, 3'd0, 3'd0, 32'h00020000);  // first sample after shrink, at position zero
    send_beat(CMD_READ, 3'd0, 3'd0);
    set_regs(16'd0, 16'd0);                          // both act as one
    send_beat(CMD_SAMPLE, 3'd0, 3'd0, 32'hfffe0000);
    send_beat(CMD_READ, 3'd0, 3'd0);
    send_beat(CMD_READ, 3'd1, 3'd0);
    set_regs(16'd15, 16'd1);                         // acts as eight
    send_beat(CMD_SAMPLE, 3'd0, 3'd0, 32'h00030000);
    send_beat(CMD_READ, 3'd7, 3'd0);
  endtask

  task automatic test_saturation();
    set_regs(16'd2, 16'd1);
    send_beat(CMD_CLEAR);
    send_beat(CMD_SCALE, 3'd0, 3'd0, 32'd1);
    send_beat(CMD_SCALE, 3'd1, 3'd0, 32'hffffffff);
    repeat (6) begin
      send_beat(CMD_SAMPLE, 3'd0, 3'd0, 32'h7fffffff);
      send_beat(CMD_SAMPLE, 3'd0, 3'd0, 32'h80000000);
    end
    send_beat(CMD_READ, 3'd0, 3'd0);
    send_beat(CMD_READ, 3'd1, 3'd0);
    send_beat(CMD_READ, 3'd1, 3'd1);
  endtask

  task automatic test_random_phase(logic [15:0] nv, logic [15:0] runs, int beats);
    int unsigned n;
    int pick, sent;
    set_regs(nv, runs);
    n = active_vars();
    if ($urandom_range(1)) send_beat(CMD_CLEAR);
    steady = 0;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        for (int k = 0; k < n; k++)
          send_beat(CMD_SAMPLE, 3'($urandom), 3'($urandom), rand_sample());
        sent += n;
      end else begin
        if (pick < 78)
          send_beat(CMD_READ, 3'($urandom_range(n - 1)), 3'($urandom_range(n - 1)),
                    $urandom);
        else if (pick < 84)
          send_beat(CMD_READ, 3'($urandom), 3'($urandom), $urandom);
        else if (pick < 92)
          send_beat(CMD_SCALE, 3'($urandom), 3'($urandom), rand_scale());
        else if (pick < 95)
          send_beat(CMD_CLEAR, 3'($urandom), 3'($urandom), $urandom);
        else
          send_beat(CMD_SAMPLE, 3'($urandom), 3'($urandom), rand_sample());  // partial vector
        sent++;
      end
      // a long run with no idling in the middle of the phase
      steady = (sent > beats / 3) && (sent < beats / 2);
    end
    steady = 0;
  endtask

  task automatic test_backpressure();
    set_regs(16'd8, 16'd3);
    hold_req = 400;
    steady = 1;
    repeat (24) send_beat(CMD_SAMPLE, 3'd0, 3'd0, rand_sample());
    send_beat(CMD_READ, 3'd6, 3'd2);
    steady = 0;
    drain();   // sender pauses until every result is back
    send_beat(CMD_READ, 3'd7, 3'd7);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.var_index = '0;
    in_ch.other_index = '0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    foreach (scales[k]) scales[k] = '0;
    foreach (last_vec[k]) last_vec[k] = '0;
    foreach (mean_acc[k]) mean_acc[k] = '0;
    foreach (cross_acc[k]) cross_acc[k] = '0;
    vec_pos = 0;
    vars_reg = 4'd8;
    runs_reg = 16'd1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic();
    test_register_edges();
    test_saturation();
    test_random_phase(16'd8, 16'd1, 200);
    test_random_phase(16'd3, 16'd5, 170);
    test_random_phase(16'd1, 16'd65535, 150);
    test_random_phase(16'd8, 16'd0, 170);
    test_random_phase(16'd5, 16'd7, 170);
    test_backpressure();
    test_random_phase(16'd2, 16'd2, 150);
    test_random_phase(16'd15, 16'd100, 170);

    drain();
    repeat (250) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
